### sv/tlbs_pkg.sv
// Shared types, widths and register codes for the text line band segmenter.
package tlbs_pkg;

  localparam int MAX_COLS = 4096;
  localparam int MAX_ROWS = 4096;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int HGT_W    = ROW_W + 1;
  localparam int WID_W    = COL_W + 1;
  localparam int PIX_W    = 8;
  localparam int CFG_W    = 13;
  localparam int CIDX_W   = 2;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0] LEFT_NONE = '1;

  localparam logic [PIX_W-1:0] ROW_LIMIT_RST  = PIX_W'(250);
  localparam logic [PIX_W-1:0] INK_LIMIT_RST  = PIX_W'(100);
  localparam logic [HGT_W-1:0] MIN_HEIGHT_RST = HGT_W'(10);
  localparam logic [WID_W-1:0] MIN_WIDTH_RST  = WID_W'(12);

  typedef enum logic [CIDX_W-1:0] {
    REG_ROW_LIMIT  = 2'd0,
    REG_INK_LIMIT  = 2'd1,
    REG_MIN_HEIGHT = 2'd2,
    REG_MIN_WIDTH  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] top_row;
    logic [HGT_W-1:0] band_height;
    logic [COL_W-1:0] left_col;
    logic [WID_W-1:0] band_width;
  } band_t;

endpackage

### sv/text_line_band_segmenter_core.sv
// Top level of the text line band segmenter.
// One pixel word per cycle while pixel_stall is low; the row-end or image-end pixel that closes
// a band registers its word into a two-entry output buffer, which absorbs downstream stalls.
// pixel_stall rises only while both output entries hold words.
// Synchronous active-high reset clears the scan state, empties the output buffer and
// loads the register defaults (row 250, ink 100, min height 10, min width 12).
module text_line_band_segmenter_core
  import tlbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              row_end,
  input  logic              image_end,
  output logic              band_valid,
  input  logic              band_stall,
  output logic [ROW_W-1:0]  top_row,
  output logic [HGT_W-1:0]  band_height,
  output logic [COL_W-1:0]  left_col,
  output logic [WID_W-1:0]  band_width
);

  logic [PIX_W-1:0] row_limit, ink_limit;
  logic [HGT_W-1:0] min_height;
  logic [WID_W-1:0] min_width;

  logic [COL_W-1:0] column_count, row_left, row_right;
  logic [ROW_W-1:0] row_count, band_top;
  logic [COL_W-1:0] band_left, band_right;
  logic             in_band, row_has_dark, row_has_ink, band_has_ink;

  logic             accept, line_end, is_dark, is_ink;
  logic             dark_next, row_ink_next, ink_prev, band_ink_next;
  logic [COL_W-1:0] row_left_next, row_right_next, band_left_next, band_right_next;
  logic [ROW_W-1:0] band_top_next;
  logic             close_blank, close_end, emit;
  logic             sel_ink;
  logic [COL_W-1:0] sel_left, sel_right;
  logic [ROW_W-1:0] sel_top;
  logic [HGT_W-1:0] height_raw, height;
  logic [WID_W-1:0] width;
  band_t            result;
  band_t            out_word;
  logic             buf_full;

  assign accept   = pixel_valid && !pixel_stall;
  assign line_end = row_end || image_end;

  assign is_dark = pixel < row_limit;
  assign is_ink  = pixel < ink_limit;

  assign dark_next      = row_has_dark || is_dark;
  assign row_ink_next   = row_has_ink || is_ink;
  assign row_left_next  = (is_ink && !row_has_ink) ? column_count : row_left;
  assign row_right_next = is_ink ? column_count : row_right;

  // band extent with this row merged in (a fresh band starts with no ink)
  assign band_top_next   = in_band ? band_top : row_count;
  assign ink_prev        = in_band && band_has_ink;
  assign band_ink_next   = ink_prev || row_ink_next;
  assign band_left_next  = (row_ink_next && (!ink_prev || row_left_next < band_left))
                           ? row_left_next : band_left;
  assign band_right_next = (row_ink_next && (!ink_prev || row_right_next > band_right))
                           ? row_right_next : band_right;

  // blank row closes the open band without it; image end closes it with this row
  assign close_blank = !dark_next && in_band;
  assign close_end   = image_end && dark_next;

  assign sel_ink   = close_end ? band_ink_next   : band_has_ink;
  assign sel_left  = close_end ? band_left_next  : band_left;
  assign sel_right = close_end ? band_right_next : band_right;
  assign sel_top   = close_end ? band_top_next   : band_top;

  assign height_raw = {1'b0, row_count} - {1'b0, sel_top} + HGT_W'(close_end);
  assign height     = (height_raw == '0) ? HGT_W'(1) : height_raw;
  assign width      = sel_ink ? ({1'b0, sel_right} - {1'b0, sel_left} + WID_W'(1))
                              : WID_W'(1);

  assign result.top_row     = sel_top;
  assign result.band_height = height;
  assign result.left_col    = sel_ink ? sel_left : '0;
  assign result.band_width  = width;

  assign emit = accept && line_end && (close_blank || close_end)
                && (height > min_height) && (width > min_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit  <= ROW_LIMIT_RST;
      ink_limit  <= INK_LIMIT_RST;
      min_height <= MIN_HEIGHT_RST;
      min_width  <= MIN_WIDTH_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_LIMIT:  row_limit  <= cfg_data[PIX_W-1:0];
        REG_INK_LIMIT:  ink_limit  <= cfg_data[PIX_W-1:0];
        REG_MIN_HEIGHT: min_height <= cfg_data[HGT_W-1:0];
        REG_MIN_WIDTH:  min_width  <= cfg_data[WID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && image_end)) begin
      column_count <= '0;
      row_count    <= '0;
      in_band      <= 1'b0;
      row_has_dark <= 1'b0;
      row_has_ink  <= 1'b0;
      row_left     <= '0;
      row_right    <= '0;
      band_top     <= '0;
      band_left    <= LEFT_NONE;
      band_right   <= '0;
      band_has_ink <= 1'b0;
    end else if (accept) begin
      if (!line_end) begin
        if (column_count != COL_LAST) begin
          column_count <= column_count + COL_W'(1);
        end
        row_has_dark <= dark_next;
        row_has_ink  <= row_ink_next;
        row_left     <= row_left_next;
        row_right    <= row_right_next;
      end else begin
        column_count <= '0;
        row_has_dark <= 1'b0;
        row_has_ink  <= 1'b0;
        row_left     <= '0;
        row_right    <= '0;
        if (row_count != ROW_LAST) begin
          row_count <= row_count + ROW_W'(1);
        end
        if (dark_next) begin
          in_band      <= 1'b1;
          band_top     <= band_top_next;
          band_left    <= band_left_next;
          band_right   <= band_right_next;
          band_has_ink <= band_ink_next;
        end else if (in_band) begin
          in_band      <= 1'b0;
          band_has_ink <= 1'b0;
          band_left    <= LEFT_NONE;
          band_right   <= '0;
        end
      end
    end
  end

  tlbs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_word (result),
    .stall     (band_stall),
    .valid     (band_valid),
    .word      (out_word),
    .full      (buf_full)
  );

  assign pixel_stall = buf_full;

  assign top_row     = out_word.top_row;
  assign band_height = out_word.band_height;
  assign left_col    = out_word.left_col;
  assign band_width  = out_word.band_width;

endmodule

### sv/tlbs_out_buf.sv
// Two-entry output buffer: result register plus skid register for band words.
module tlbs_out_buf
  import tlbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  band_t push_word,
  input  logic  stall,
  output logic  valid,
  output band_t word,
  output logic  full
);

  logic  skid_valid;
  band_t skid_word;
  logic  take;

  assign take = valid && !stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!valid || take) begin
        // head is free this cycle: oldest word moves up
        if (skid_valid) begin
          word       <= skid_word;
          valid      <= 1'b1;
          skid_valid <= push;
          skid_word  <= push_word;
        end else begin
          valid <= push;
          word  <= push_word;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_word  <= push_word;
      end
    end
  end

endmodule

### sv/tlbs_checker.sv
// Port-level checker for the text line band segmenter, bound to the top level.
module tlbs_checker
  import tlbs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             pixel_valid,
  input logic             pixel_stall,
  input logic             row_end,
  input logic             image_end,
  input logic             band_valid,
  input logic             band_stall,
  input logic [ROW_W-1:0] top_row,
  input logic [HGT_W-1:0] band_height,
  input logic [COL_W-1:0] left_col,
  input logic [WID_W-1:0] band_width
);

  // a held band word keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    band_valid && band_stall |=> band_valid && $stable(top_row) && $stable(band_height)
      && $stable(left_col) && $stable(band_width))
    else $error("band word changed while stalled");

  // a new band word only follows an accepted row-end or image-end pixel
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(band_valid) |-> $past(pixel_valid && !pixel_stall && (row_end || image_end)))
    else $error("band word without a closing pixel");

  // the ink extent stays inside the image and sizes are never zero
  a_extent: assert property (@(posedge clk) disable iff (rst)
    band_valid |-> band_height != '0 && band_width != '0
      && ({2'b0, left_col} + {1'b0, band_width}) <= (WID_W + 1)'(MAX_COLS))
    else $error("band word out of range");

  // input backs up only when the output side is holding words
  a_stall: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> band_valid)
    else $error("input stalled with empty output");

endmodule

bind text_line_band_segmenter_core tlbs_checker u_tlbs_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .row_end     (row_end),
  .image_end   (image_end),
  .band_valid  (band_valid),
  .band_stall  (band_stall),
  .top_row     (top_row),
  .band_height (band_height),
  .left_col    (left_col),
  .band_width  (band_width)
);

### tb/text_line_band_segmenter_core_tb.sv
// Self-checking testbench for the text line band segmenter core.
module text_line_band_segmenter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic [PIX_W-1:0]  pixel = '0;
  logic              row_end = 1'b0;
  logic              image_end = 1'b0;
  logic              band_valid;
  logic              band_stall = 1'b0;
  logic [ROW_W-1:0]  top_row;
  logic [HGT_W-1:0]  band_height;
  logic [COL_W-1:0]  left_col;
  logic [WID_W-1:0]  band_width;

  text_line_band_segmenter_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scan state mirrored from the block
  logic [PIX_W-1:0] lim_row, lim_ink;
  logic [HGT_W-1:0] lim_height;
  logic [WID_W-1:0] lim_width;
  logic [COL_W-1:0] scan_col, ink_left, ink_right, row_ink_left, row_ink_right;
  logic [ROW_W-1:0] scan_row, line_top;
  bit               line_open, row_dark, row_ink, line_ink;

  band_t       expected_bands[$];
  longint unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned mismatches = 0;
  int unsigned hold_requests = 0;
  int unsigned cycle_count = 0;

  task automatic clear_scan();
    scan_col = '0;
    scan_row = '0;
    line_open = 1'b0;
    row_dark = 1'b0;
    line_top = '0;
    ink_left = LEFT_NONE;
    ink_right = '0;
    line_ink = 1'b0;
    row_ink = 1'b0;
    row_ink_left = '0;
    row_ink_right = '0;
  endtask

  task automatic close_line(logic [HGT_W-1:0] height);
    logic [COL_W-1:0] span;
    band_t b;
    span = ink_right - ink_left;
    b.top_row = line_top;
    b.band_height = (height == '0) ? HGT_W'(1) : height;
    b.left_col = line_ink ? ink_left : '0;
    b.band_width = line_ink ? {1'b0, span} + WID_W'(1) : WID_W'(1);
    line_open = 1'b0;
    line_ink = 1'b0;
    ink_left = LEFT_NONE;
    ink_right = '0;
    if (b.band_height > lim_height && b.band_width > lim_width) begin
      expected_bands = {expected_bands, b};
    end
  endtask

  task automatic predict_word(logic [PIX_W-1:0] p, bit re, bit ie);
    if (p < lim_row) row_dark = 1'b1;
    if (p < lim_ink) begin
      if (!row_ink) row_ink_left = scan_col;
      row_ink_right = scan_col;
      row_ink = 1'b1;
    end
    if (!re && !ie) begin
      if (scan_col != COL_LAST) scan_col++;
      return;
    end
    if (row_dark) begin
      if (!line_open) begin
        line_open = 1'b1;
        line_top = scan_row;
        line_ink = 1'b0;
      end
      if (row_ink) begin
        if (!line_ink || row_ink_left < ink_left) ink_left = row_ink_left;
        if (!line_ink || row_ink_right > ink_right) ink_right = row_ink_right;
        line_ink = 1'b1;
      end
    end else if (line_open) begin
      // blank row: band ends on the row above
      close_line({1'b0, scan_row} - {1'b0, line_top});
    end
    if (ie) begin
      if (line_open) close_line({1'b0, scan_row} - {1'b0, line_top} + HGT_W'(1));
      clear_scan();
      return;
    end
    scan_col = '0;
    row_dark = 1'b0;
    row_ink = 1'b0;
    row_ink_left = '0;
    row_ink_right = '0;
    if (scan_row != ROW_LAST) scan_row++;
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_band();
    band_t want;
    if (expected_bands.size() == 0) begin
      report_mismatch($sformatf("band word with none pending: top %0d height %0d left %0d width %0d",
                                top_row, band_height, left_col, band_width));
      return;
    end
    want = expected_bands.pop_front();
    if (top_row !== want.top_row)
      report_mismatch($sformatf("top_row %0d, want %0d", top_row, want.top_row));
    if (band_height !== want.band_height)
      report_mismatch($sformatf("band_height %0d, want %0d", band_height, want.band_height));
    if (left_col !== want.left_col)
      report_mismatch($sformatf("left_col %0d, want %0d", left_col, want.left_col));
    if (band_width !== want.band_width)
      report_mismatch($sformatf("band_width %0d, want %0d", band_width, want.band_width));
  endtask

  // Band receiver: checks words and stalls on its own pattern
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk) begin
    if (!rst && band_valid && !band_stall) check_band();
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 64);
    end else begin
      rx_mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      band_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:  band_stall <= 1'b0;
        RX_LIGHT: band_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: band_stall <= ($urandom_range(0, 3) != 0);
        default:  band_stall <= ~band_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one pixel word; valid stays high so the next call can follow at once.
  task automatic send_pixel(logic [PIX_W-1:0] p, bit re, bit ie);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    row_end <= re;
    image_end <= ie;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    predict_word(p, re, ie);
    burst_left--;
    words_sent++;
  endtask

  // Ink (0) at two columns, fill 200 on dark rows and 255 on blank rows
  task automatic send_row(int cols, int ink_a, int ink_b, bit dark, bit last);
    logic [PIX_W-1:0] p;
    for (int c = 0; c < cols; c++) begin
      p = (c == ink_a || c == ink_b) ? 8'd0 : (dark ? 8'd200 : 8'd255);
      send_pixel(p, c == cols - 1, last && c == cols - 1);
    end
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (expected_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic put_reg(cfg_reg_t idx, int unsigned v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(v);
    @(posedge clk);
  endtask

  task automatic set_limits(int unsigned r, int unsigned i, int unsigned h, int unsigned w);
    put_reg(REG_ROW_LIMIT, r);
    put_reg(REG_INK_LIMIT, i);
    put_reg(REG_MIN_HEIGHT, h);
    put_reg(REG_MIN_WIDTH, w);
    cfg_write <= 1'b0;
    lim_row = PIX_W'(r);
    lim_ink = PIX_W'(i);
    lim_height = HGT_W'(h);
    lim_width = WID_W'(w);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(bit dark);
    int unsigned k;
    k = $urandom_range(0, 9);
    if (dark && lim_row != 0 && k < 3) return PIX_W'($urandom_range(0, lim_row - 1));
    if (dark && lim_ink != 0 && k == 3) return PIX_W'($urandom_range(0, lim_ink - 1));
    if (k == 9) return PIX_W'($urandom_range(0, 255));
    return PIX_W'($urandom_range(lim_row, 255));
  endfunction

  // Bands just at and just past the reset minimums
  task automatic test_reset_settings();
    for (int r = 0; r < 10; r++) send_row(13, 0, 12, 1'b1, 1'b0);
    send_row(13, -1, -1, 1'b0, 1'b0);
    for (int r = 0; r < 11; r++) send_row(13, 0, 12, 1'b1, 1'b0);
    send_row(13, -1, -1, 1'b0, 1'b0);
    for (int r = 0; r < 11; r++) send_row(12, 0, 11, 1'b1, r == 10);
    drain();
  endtask

  task automatic test_directed();
    set_limits(250, 100, 0, 0);
    // blank row, two-row band with ink, blank row closes it
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd250, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd120, 1'b0, 1'b0);
    send_pixel(8'd99, 1'b1, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b0);
    send_pixel(8'd100, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    // band without ink, closed by image end on a row with no row end
    send_pixel(8'd240, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b1);
    // band still open at image end, row end and image end together
    send_pixel(8'd50, 1'b1, 1'b0);
    send_pixel(8'd0, 1'b0, 1'b0);
    send_pixel(8'd5, 1'b1, 1'b1);
    drain();
    // ink threshold above row threshold: ink in a blank row is dropped
    set_limits(50, 200, 0, 0);
    send_pixel(8'd100, 1'b0, 1'b0);
    send_pixel(8'd150, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd10, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b1);
    drain();
  endtask

  // Receiver holds off while one-row bands keep coming; the output buffer fills
  task automatic test_output_backpressure();
    set_limits(250, 100, 0, 0);
    hold_requests++;
    for (int r = 0; r < 60; r++) send_row(1, (r % 2 == 0) ? 0 : -1, -1, r % 2 == 0, r == 59);
    drain();
  endtask

  task automatic pick_random_limits();
    int unsigned row_v;
    case ($urandom_range(0, 7))
      0: set_limits(255, 255, 0, 0);
      1: set_limits(0, 0, 4096, 4096);
      2: set_limits(ROW_LIMIT_RST, INK_LIMIT_RST, MIN_HEIGHT_RST, MIN_WIDTH_RST);
      3: set_limits(250, 0, 0, 0);
      4: set_limits($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 4096), $urandom_range(0, 4096));
      default: begin
        row_v = $urandom_range(100, 255);
        set_limits(row_v, $urandom_range(0, 255) % (row_v + 1) == 0 ? $urandom_range(0, 255)
                   : $urandom_range(0, row_v), $urandom_range(0, 3), $urandom_range(0, 6));
      end
    endcase
  endtask

  task automatic random_image();
    int unsigned cols, rows, run_left, row_cols, dark_col, last_col, words;
    bit dark, ragged, cut;
    logic [PIX_W-1:0] p;
    if ($urandom_range(0, 9) == 0) begin
      // noise: random pixels and row ends
      words = $urandom_range(10, 80);
      for (int n = 0; n < words; n++)
        send_pixel(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0, n == words - 1);
      return;
    end
    cols = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    rows = $urandom_range(2, 24);
    ragged = ($urandom_range(0, 3) == 0);
    cut = ($urandom_range(0, 3) == 0);
    dark = $urandom_range(0, 1);
    run_left = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      if (run_left == 0) begin
        dark = !dark;
        if (dark)
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 6);
        else
          run_left = $urandom_range(1, 3);
      end
      run_left--;
      row_cols = ragged ? $urandom_range(1, 2 * cols) : cols;
      dark_col = $urandom_range(0, row_cols - 1);
      // a cut image ends partway through its last row
      last_col = (cut && r == rows - 1) ? $urandom_range(0, row_cols - 1) : row_cols - 1;
      for (int c = 0; c <= last_col; c++) begin
        p = pick_pixel(dark);
        if (dark && c == dark_col && lim_row != 0) p = PIX_W'($urandom_range(0, lim_row - 1));
        send_pixel(p, c == row_cols - 1, r == rows - 1 && c == last_col);
      end
    end
  endtask

  task automatic test_random_images();
    longint unsigned word_start;
    int unsigned images;
    word_start = words_sent;
    images = 0;
    while (words_sent - word_start < RANDOM_WORDS) begin
      if (images % 2 == 0) begin
        drain();
        pick_random_limits();
      end
      random_image();
      images++;
    end
    drain();
  endtask

  initial begin
    lim_row = ROW_LIMIT_RST;
    lim_ink = INK_LIMIT_RST;
    lim_height = MIN_HEIGHT_RST;
    lim_width = MIN_WIDTH_RST;
    clear_scan();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_settings();
    test_directed();
    test_output_backpressure();
    test_random_images();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
